### hw/rtl/lse_pkg.sv
`default_nettype none

package lse_pkg;

  localparam int GROUP_COUNT = 4;
  localparam int GROUP_IDX_W = $clog2(GROUP_COUNT);

  localparam logic [1:0] MODE_LSB1 = 2'd0;
  localparam logic [1:0] MODE_LSB4 = 2'd1;
  localparam logic [1:0] MODE_LSBI = 2'd2;

  localparam logic CFG_MODE       = 1'b0;
  localparam logic CFG_IMAGE_SIZE = 1'b1;

  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_SIZE_OK  = 2'd1;
  localparam logic [1:0] KIND_SIZE_ERR = 2'd2;

  localparam logic [1:0] HEADER_LAST = 2'd3;

  typedef enum logic [3:0] {
    PH_GROUP   = 4'b0001,
    PH_HEADER  = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_DONE    = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/lse_core.sv
`default_nettype none

module lse_core
  import lse_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  carrier,
  input  logic [1:0]  mode,
  input  logic [31:0] image_size,
  output logic        res_valid,
  output result_t     res
);

  phase_t                 phase, phase_next;
  logic [GROUP_COUNT-1:0] group_flags, group_flags_next;
  logic [7:0]             bit_accum, bit_accum_next;
  logic [2:0]             bit_count, bit_count_next;
  logic [31:0]            size_shift, size_shift_next;
  logic [1:0]             header_byte_count, header_byte_count_next;
  logic [31:0]            payload_remaining, payload_remaining_next;

  always_comb begin
    logic                   go;
    logic [2:0]             cnt;
    phase_t                 ph;
    logic [GROUP_IDX_W-1:0] idx;
    logic [7:0]             acc_new;
    logic [3:0]             sum;
    logic [31:0]            shift_new;
    logic [34:0]            need;
    logic [31:0]            rem_new;

    phase_next             = phase;
    group_flags_next       = group_flags;
    bit_accum_next         = bit_accum;
    bit_count_next         = bit_count;
    size_shift_next        = size_shift;
    header_byte_count_next = header_byte_count;
    payload_remaining_next = payload_remaining;
    res_valid              = 1'b0;
    res                    = '0;

    go        = (phase != PH_DONE);
    cnt       = bit_count;
    ph        = phase;
    idx       = bit_count[GROUP_IDX_W-1:0];
    acc_new   = bit_accum;
    sum       = 4'd0;
    shift_new = {size_shift[23:0], acc_new};
    need      = '0;
    rem_new   = payload_remaining - 32'd1;

    if (phase == PH_GROUP) begin
      if (mode == MODE_LSBI) begin
        go = 1'b0;
        group_flags_next = group_flags | (GROUP_COUNT'(carrier[0]) << idx);
        if (idx == GROUP_IDX_W'(GROUP_COUNT - 1)) begin
          bit_count_next = 3'd0;
          phase_next     = PH_HEADER;
        end else begin
          bit_count_next = 3'(idx + GROUP_IDX_W'(1));
        end
      end else begin
        cnt = 3'd0;
        ph  = PH_HEADER;
      end
    end

    if (go) begin
      phase_next = ph;
      unique case (mode)
        MODE_LSB4: begin
          acc_new = {bit_accum[3:0], carrier[3:0]};
          sum     = {1'b0, cnt} + 4'd4;
        end
        MODE_LSBI: begin
          acc_new = {bit_accum[6:0], carrier[0] ^ group_flags[carrier[2:1]]};
          sum     = {1'b0, cnt} + 4'd1;
        end
        default: begin
          acc_new = {bit_accum[6:0], carrier[0]};
          sum     = {1'b0, cnt} + 4'd1;
        end
      endcase
      bit_accum_next = acc_new;
      shift_new      = {size_shift[23:0], acc_new};
      if (sum[3]) begin
        bit_count_next = 3'd0;
        if (ph == PH_HEADER) begin
          size_shift_next = shift_new;
          if (header_byte_count != HEADER_LAST) begin
            header_byte_count_next = header_byte_count + 2'd1;
          end else begin
            header_byte_count_next = 2'd0;
            need = (mode == MODE_LSB4) ? {2'b0, shift_new, 1'b0} : {shift_new, 3'b0};
            res_valid = 1'b1;
            res.value = shift_new;
            if (need > {3'b0, image_size}) begin
              res.kind   = KIND_SIZE_ERR;
              res.last   = 1'b0;
              phase_next = PH_DONE;
            end else begin
              res.kind               = KIND_SIZE_OK;
              res.last               = (shift_new == 32'd0);
              payload_remaining_next = shift_new;
              phase_next             = (shift_new == 32'd0) ? PH_DONE : PH_PAYLOAD;
            end
          end
        end else begin
          payload_remaining_next = rem_new;
          res_valid = 1'b1;
          res.kind  = KIND_PAYLOAD;
          res.value = {24'd0, acc_new};
          res.last  = (rem_new == 32'd0);
          if (rem_new == 32'd0) begin
            phase_next = PH_DONE;
          end
        end
      end else begin
        bit_count_next = sum[2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_GROUP;
      group_flags       <= '0;
      bit_accum         <= '0;
      bit_count         <= '0;
      size_shift        <= '0;
      header_byte_count <= '0;
      payload_remaining <= '0;
    end else if (step) begin
      phase             <= phase_next;
      group_flags       <= group_flags_next;
      bit_accum         <= bit_accum_next;
      bit_count         <= bit_count_next;
      size_shift        <= size_shift_next;
      header_byte_count <= header_byte_count_next;
      payload_remaining <= payload_remaining_next;
    end
  end

`ifndef SYNTH
  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DONE |-> !res_valid)
    else $error("result produced after the stream ended");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    step && res_valid && res.last |=> phase == PH_DONE)
    else $error("final item did not end the stream");

  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> payload_remaining != 32'd0)
    else $error("payload phase with nothing remaining");
`endif

endmodule

`default_nettype wire

### hw/rtl/lsb_stego_extractor_top.sv
// Recovers bytes hidden in the low bits of a stream of carrier image bytes.
// Carrier bytes enter on carrier_byte with carrier_valid/carrier_ready; results
// leave on kind, value and last with result_valid/result_ready. The first four
// hidden bytes form a big-endian size that comes out once as a size-accepted
// or size-error item, and the payload bytes follow as payload items.
// Configuration (mode, image_size) is written through cfg_we, cfg_index and
// cfg_data; the user must do so only while the block is idle, which the block
// itself does not enforce. One carrier item is taken every cycle while the
// receiver does not stall. An accepted carrier is held in the input register
// and decoded from there into the output register, where its result becomes
// visible. The rate is set by the single decode step between the two registers.
// When the receiver stalls, a waiting result holds in the output register and
// one more carrier waits in the input register; then carrier_ready drops.
// Reset clears the configuration and returns the decoder to its start phase.
// After the last payload item or a size error, carriers are accepted and
// dropped until the next reset.
`default_nettype none

module lsb_stego_extractor_top
  import lse_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        carrier_valid,
  output logic        carrier_ready,
  input  logic [7:0]  carrier_byte,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [1:0]  kind,
  output logic [31:0] value,
  output logic        last
);

  logic [1:0]  mode;
  logic [31:0] image_size;
  logic        in_full;
  logic [7:0]  in_byte;
  logic        out_full;
  result_t     out_res;
  logic        step;
  logic        res_valid;
  result_t     res;

  assign step          = in_full && (!out_full || result_ready);
  assign carrier_ready = !in_full || step;
  assign result_valid  = out_full;
  assign kind          = out_res.kind;
  assign value         = out_res.value;
  assign last          = out_res.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_LSB1;
      image_size <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MODE) begin
        mode <= cfg_data[1:0];
      end else begin
        image_size <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full  <= 1'b0;
      out_full <= 1'b0;
    end else begin
      if (carrier_valid && carrier_ready) begin
        in_full <= 1'b1;
      end else if (step) begin
        in_full <= 1'b0;
      end
      if (step) begin
        out_full <= res_valid;
      end else if (result_ready) begin
        out_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (carrier_valid && carrier_ready) begin
      in_byte <= carrier_byte;
    end
    if (step && res_valid) begin
      out_res <= res;
    end
  end

  lse_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .carrier    (in_byte),
    .mode       (mode),
    .image_size (image_size),
    .res_valid  (res_valid),
    .res        (res)
  );

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    in_full && carrier_valid && carrier_ready |-> step)
    else $error("held carrier item overwritten before decode");
`endif

endmodule

`default_nettype wire
